FILE: rtl/lnsa_pkg.sv
// Shared constants for the letterbox nearest-neighbour scaler address block.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package lnsa_pkg;

    localparam int REG_W       = 13;
    localparam int COORD_W     = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int MAX_DIM_DEF = 4096;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_DST_WIDTH  = 3'd2,
        CFG_DST_HEIGHT = 3'd3
    } cfg_index_t;

endpackage

FILE: rtl/lnsa_setup.sv
// Configuration registers and the sequencer that derives the picture geometry.
// Depends on lnsa_pkg.
`timescale 1ns / 1ps

module lnsa_setup #(
    parameter int MAX_DIM = lnsa_pkg::MAX_DIM_DEF,
    parameter int D       = $clog2(MAX_DIM + 1)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [lnsa_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [lnsa_pkg::REG_W-1:0]     cfg_wr_data,
    output logic                           ready,
    output logic [8*D:0]                   geom
);

    typedef struct packed {
        logic         zero;
        logic [D-1:0] sw;
        logic [D-1:0] sh;
        logic [D-1:0] dw;
        logic [D-1:0] dh;
        logic [D-1:0] tw;
        logic [D-1:0] th;
        logic [D-1:0] ox;
        logic [D-1:0] oy;
    } geom_t;

    localparam int P     = 2 * D;
    localparam int NUM_W = P + 2;
    localparam int CNT_W = $clog2(NUM_W);

    typedef enum logic [2:0] {
        ST_LOAD, ST_MUL_A, ST_MUL_B, ST_PREP, ST_DIV, ST_FIN, ST_OFS, ST_DONE
    } state_t;

    state_t                   state_reg;
    logic [lnsa_pkg::REG_W-1:0] sw_cfg_reg, sh_cfg_reg, dw_cfg_reg, dh_cfg_reg;
    geom_t                    g_reg;
    logic [P-1:0]             pa_reg, pb_reg;
    logic                     fit_reg;
    logic [NUM_W-1:0]         num_reg, q_reg;
    logic [D:0]               den_reg, rem_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [D+1:0]             rem_sh;
    logic [D-1:0]             q_clamped;
    logic [NUM_W-1:0]         dlim;

    function automatic logic [D-1:0] sat(input logic [lnsa_pkg::REG_W-1:0] v);
        logic [31:0] ve;
        ve = 32'(v);
        sat = (ve > 32'(MAX_DIM)) ? D'(MAX_DIM) : D'(ve);
    endfunction

    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign dlim   = fit_reg ? NUM_W'(g_reg.dh) : NUM_W'(g_reg.dw);
    assign q_clamped = (q_reg == '0) ? D'(1) : ((q_reg > dlim) ? D'(dlim) : D'(q_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            sw_cfg_reg <= '0;
            sh_cfg_reg <= '0;
            dw_cfg_reg <= '0;
            dh_cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            state_reg <= ST_LOAD;
            case (cfg_wr_index)
                lnsa_pkg::CFG_SRC_WIDTH:  sw_cfg_reg <= cfg_wr_data;
                lnsa_pkg::CFG_SRC_HEIGHT: sh_cfg_reg <= cfg_wr_data;
                lnsa_pkg::CFG_DST_WIDTH:  dw_cfg_reg <= cfg_wr_data;
                lnsa_pkg::CFG_DST_HEIGHT: dh_cfg_reg <= cfg_wr_data;
                default: ;
            endcase
        end else begin
            case (state_reg)
                ST_LOAD: begin
                    g_reg.sw   <= sat(sw_cfg_reg);
                    g_reg.sh   <= sat(sh_cfg_reg);
                    g_reg.dw   <= sat(dw_cfg_reg);
                    g_reg.dh   <= sat(dh_cfg_reg);
                    g_reg.zero <= (sw_cfg_reg == '0) || (sh_cfg_reg == '0) ||
                                  (dw_cfg_reg == '0) || (dh_cfg_reg == '0);
                    state_reg  <= ST_MUL_A;
                end
                ST_MUL_A: begin
                    pa_reg    <= P'(g_reg.dw) * P'(g_reg.sh);
                    state_reg <= ST_MUL_B;
                end
                ST_MUL_B: begin
                    pb_reg    <= P'(g_reg.dh) * P'(g_reg.sw);
                    state_reg <= ST_PREP;
                end
                ST_PREP: begin
                    fit_reg <= (pa_reg <= pb_reg);
                    if (pa_reg <= pb_reg) begin
                        num_reg <= {pa_reg, 1'b0} + NUM_W'(g_reg.sw);
                        den_reg <= {g_reg.sw, 1'b0};
                    end else begin
                        num_reg <= {pb_reg, 1'b0} + NUM_W'(g_reg.sh);
                        den_reg <= {g_reg.sh, 1'b0};
                    end
                    rem_reg   <= '0;
                    q_reg     <= '0;
                    cnt_reg   <= CNT_W'(NUM_W - 1);
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                    if (rem_sh >= (D+2)'(den_reg)) begin
                        rem_reg <= (D+1)'(rem_sh - (D+2)'(den_reg));
                        q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh[D:0];
                        q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (fit_reg) begin
                        g_reg.tw <= g_reg.dw;
                        g_reg.th <= q_clamped;
                    end else begin
                        g_reg.th <= g_reg.dh;
                        g_reg.tw <= q_clamped;
                    end
                    state_reg <= ST_OFS;
                end
                ST_OFS: begin
                    g_reg.ox  <= D'((g_reg.dw - g_reg.tw) >> 1);
                    g_reg.oy  <= D'((g_reg.dh - g_reg.th) >> 1);
                    state_reg <= ST_DONE;
                end
                ST_DONE: ;
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    assign ready = (state_reg == ST_DONE);
    assign geom  = g_reg;

endmodule

FILE: rtl/lnsa_front.sv
// Front end: accepts destination coordinates and classifies them against the picture area.
// Depends on lnsa_pkg; feeds lnsa_queue.
`timescale 1ns / 1ps

module lnsa_front #(
    parameter int D = 13
) (
    input  logic [8*D:0]                 geom,
    input  logic [lnsa_pkg::COORD_W-1:0] dest_x,
    input  logic [lnsa_pkg::COORD_W-1:0] dest_y,
    output logic [2*D:0]                 entry
);

    typedef struct packed {
        logic         zero;
        logic [D-1:0] sw;
        logic [D-1:0] sh;
        logic [D-1:0] dw;
        logic [D-1:0] dh;
        logic [D-1:0] tw;
        logic [D-1:0] th;
        logic [D-1:0] ox;
        logic [D-1:0] oy;
    } geom_t;

    typedef struct packed {
        logic         in_pic;
        logic [D-1:0] rx;
        logic [D-1:0] ry;
    } entry_t;

    localparam int CW = ((D > lnsa_pkg::COORD_W) ? D : lnsa_pkg::COORD_W) + 1;

    geom_t         g;
    entry_t        e;
    logic [CW-1:0] dxe, dye, rxe, rye;
    logic          in_area;

    assign g   = geom;
    assign dxe = CW'(dest_x);
    assign dye = CW'(dest_y);
    assign rxe = dxe - CW'(g.ox);
    assign rye = dye - CW'(g.oy);

    assign in_area = !g.zero && (dxe >= CW'(g.ox)) && (dye >= CW'(g.oy)) &&
                     (rxe < CW'(g.tw)) && (rye < CW'(g.th));

    always_comb begin
        e.in_pic = in_area;
        e.rx     = in_area ? D'(rxe) : '0;
        e.ry     = in_area ? D'(rye) : '0;
    end

    assign entry = e;

endmodule

FILE: rtl/lnsa_queue.sv
// Short first-in first-out queue between the front end and the divider pipeline.
// Depends on lnsa_pkg for its depth.
`timescale 1ns / 1ps

module lnsa_queue #(
    parameter int W = 27
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         full,
    output logic         empty
);

    localparam int N  = lnsa_pkg::QUEUE_DEPTH;
    localparam int AW = $clog2(N);

    logic [W-1:0] mem_reg [N];
    logic [AW:0]  wr_ptr_reg, rd_ptr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg[AW-1:0]] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg[AW-1:0]];
    assign empty   = (wr_ptr_reg == rd_ptr_reg);
    assign full    = (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]) &&
                     (wr_ptr_reg[AW] != rd_ptr_reg[AW]);

endmodule

FILE: rtl/lnsa_back.sv
// Back end: scales the picture-relative offsets and divides them in a bit-per-stage pipeline.
// Depends on lnsa_pkg; pops lnsa_queue and drives the result channel.
`timescale 1ns / 1ps

module lnsa_back #(
    parameter int D = 13
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [8*D:0]                 geom,
    input  logic [2*D:0]                 entry,
    input  logic                         q_empty,
    output logic                         q_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_in_picture,
    output logic [lnsa_pkg::COORD_W-1:0] m_src_col,
    output logic [lnsa_pkg::COORD_W-1:0] m_src_row
);

    typedef struct packed {
        logic         zero;
        logic [D-1:0] sw;
        logic [D-1:0] sh;
        logic [D-1:0] dw;
        logic [D-1:0] dh;
        logic [D-1:0] tw;
        logic [D-1:0] th;
        logic [D-1:0] ox;
        logic [D-1:0] oy;
    } geom_t;

    typedef struct packed {
        logic         in_pic;
        logic [D-1:0] rx;
        logic [D-1:0] ry;
    } entry_t;

    localparam int P  = 2 * D;
    localparam int NS = D;

    geom_t        g;
    entry_t       e;
    logic         adv;
    logic         v_reg  [NS+1];
    logic         in_reg [NS+1];
    logic [P-1:0] rx_reg [NS+1];
    logic [P-1:0] ry_reg [NS+1];
    logic [D-1:0] qx_reg [NS+1];
    logic [D-1:0] qy_reg [NS+1];

    assign g     = geom;
    assign e     = entry;
    assign adv   = !v_reg[NS] || m_ready;
    assign q_pop = adv && !q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= NS; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            v_reg[0] <= q_pop;
            for (int k = 1; k <= NS; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_reg[0] <= e.in_pic;
            rx_reg[0] <= P'(e.rx) * P'(g.sw);
            ry_reg[0] <= P'(e.ry) * P'(g.sh);
            qx_reg[0] <= '0;
            qy_reg[0] <= '0;
            for (int k = 1; k <= NS; k++) begin
                in_reg[k] <= in_reg[k-1];
                if (rx_reg[k-1] >= (P'(g.tw) << (NS - k))) begin
                    rx_reg[k]            <= rx_reg[k-1] - (P'(g.tw) << (NS - k));
                    qx_reg[k]            <= qx_reg[k-1] | (D'(1) << (NS - k));
                end else begin
                    rx_reg[k] <= rx_reg[k-1];
                    qx_reg[k] <= qx_reg[k-1];
                end
                if (ry_reg[k-1] >= (P'(g.th) << (NS - k))) begin
                    ry_reg[k] <= ry_reg[k-1] - (P'(g.th) << (NS - k));
                    qy_reg[k] <= qy_reg[k-1] | (D'(1) << (NS - k));
                end else begin
                    ry_reg[k] <= ry_reg[k-1];
                    qy_reg[k] <= qy_reg[k-1];
                end
            end
        end
    end

    assign m_valid      = v_reg[NS];
    assign m_in_picture = in_reg[NS];
    assign m_src_col    = in_reg[NS] ? lnsa_pkg::COORD_W'(qx_reg[NS]) : '0;
    assign m_src_row    = in_reg[NS] ? lnsa_pkg::COORD_W'(qy_reg[NS]) : '0;

endmodule

FILE: rtl/letterbox_nearest_scaler_address.sv
// Letterbox nearest-neighbour scaler address generator, top level.
// Throughput: one transaction per cycle while setup is done and m_ready is high, set by the
// bit-per-stage divider pipeline. After reset and after every register write the geometry
// sequencer loads the registers, forms and compares both cross products, runs the division
// one quotient bit a cycle, clamps the size and sets the offsets, with s_ready low; reset clears the
// configuration registers, the queue and the pipeline valid bits.
// Depends on lnsa_pkg, lnsa_setup, lnsa_front, lnsa_queue and lnsa_back.
`timescale 1ns / 1ps

module letterbox_nearest_scaler_address #(
    parameter int MAX_DIM = lnsa_pkg::MAX_DIM_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [lnsa_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [lnsa_pkg::REG_W-1:0]     cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [lnsa_pkg::COORD_W-1:0]   s_dest_x,
    input  logic [lnsa_pkg::COORD_W-1:0]   s_dest_y,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_in_picture,
    output logic [lnsa_pkg::COORD_W-1:0]   m_src_col,
    output logic [lnsa_pkg::COORD_W-1:0]   m_src_row
);

    localparam int D = $clog2(MAX_DIM + 1);

    logic [8*D:0] geom;
    logic [2*D:0] entry_in, entry_out;
    logic         setup_ready, q_full, q_empty, q_pop, q_push;

    lnsa_setup #(.MAX_DIM(MAX_DIM), .D(D)) u_setup (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data),
        .ready       (setup_ready),
        .geom        (geom)
    );

    lnsa_front #(.D(D)) u_front (
        .geom  (geom),
        .dest_x(s_dest_x),
        .dest_y(s_dest_y),
        .entry (entry_in)
    );

    assign s_ready = setup_ready && !q_full;
    assign q_push  = s_valid && s_ready;

    lnsa_queue #(.W(2*D+1)) u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .wr_en  (q_push),
        .wr_data(entry_in),
        .rd_en  (q_pop),
        .rd_data(entry_out),
        .full   (q_full),
        .empty  (q_empty)
    );

    lnsa_back #(.D(D)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .geom        (geom),
        .entry       (entry_out),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_in_picture(m_in_picture),
        .m_src_col   (m_src_col),
        .m_src_row   (m_src_row)
    );

    a_black_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_in_picture |-> (m_src_col == '0) && (m_src_row == '0))
        else $error("Black fill transaction carries a nonzero source coordinate.");

    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_ready)
        else $error("Input accepted while the geometry is being recomputed.");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("Queue popped while empty.");

endmodule

FILE: sim/tb_letterbox_nearest_scaler_address.sv
// Self-checking testbench for the letterbox nearest-neighbour scaler address block.
// It depends on lnsa_pkg and letterbox_nearest_scaler_address, and has its own
// integer model of the letterbox geometry against which each result is compared.
`timescale 1ns / 1ps

module tb_letterbox_nearest_scaler_address;

    localparam int REG_W     = lnsa_pkg::REG_W;
    localparam int COORD_W   = lnsa_pkg::COORD_W;
    localparam int CFG_IDX_W = lnsa_pkg::CFG_IDX_W;
    localparam int MAX_DIM   = lnsa_pkg::MAX_DIM_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd5;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } pixel_t;

    typedef struct {
        logic               in_picture;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } mapping_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_wr_index;
    logic [REG_W-1:0]     cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [COORD_W-1:0]   s_dest_x;
    logic [COORD_W-1:0]   s_dest_y;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_in_picture;
    logic [COORD_W-1:0]   m_src_col;
    logic [COORD_W-1:0]   m_src_row;

    logic [REG_W-1:0] geo_sw, geo_sh, geo_dw, geo_dh;
    pixel_t   pixel_q[$];
    mapping_t mapping_q[$];
    int       error_count;
    int       burst_left, gap_left;
    int       gap_pct, stall_pct;
    logic     long_hold_req;
    int       hold_left;

    letterbox_nearest_scaler_address #(.MAX_DIM(MAX_DIM)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_dest_x(s_dest_x), .s_dest_y(s_dest_y),
        .m_valid(m_valid), .m_ready(m_ready), .m_in_picture(m_in_picture),
        .m_src_col(m_src_col), .m_src_row(m_src_row)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic longint unsigned clamp_dim(logic [REG_W-1:0] v);
        return (v > MAX_DIM) ? longint'(MAX_DIM) : longint'(v);
    endfunction

    function automatic mapping_t map_pixel(pixel_t p);
        longint unsigned sw, sh, dw, dh, dx, dy, tw, th, ox, oy, rx, ry;
        mapping_t m;
        m = '{1'b0, '0, '0};
        sw = clamp_dim(geo_sw);
        sh = clamp_dim(geo_sh);
        dw = clamp_dim(geo_dw);
        dh = clamp_dim(geo_dh);
        dx = p.x;
        dy = p.y;
        if (sw == 0 || sh == 0 || dw == 0 || dh == 0) return m;
        if (dx >= dw || dy >= dh) return m;
        if (sw == dw && sh == dh) begin
            m = '{1'b1, p.x, p.y};
            return m;
        end
        if (dw * sh <= dh * sw) begin
            tw = dw;
            th = (2 * sh * dw + sw) / (2 * sw);
        end else begin
            th = dh;
            tw = (2 * sw * dh + sh) / (2 * sh);
        end
        if (tw < 1) tw = 1;
        if (th < 1) th = 1;
        if (tw > dw) tw = dw;
        if (th > dh) th = dh;
        ox = (dw - tw) / 2;
        oy = (dh - th) / 2;
        if (dx < ox || dy < oy) return m;
        rx = dx - ox;
        ry = dy - oy;
        if (rx >= tw || ry >= th) return m;
        m.in_picture = 1'b1;
        m.col = COORD_W'((rx * sw) / tw);
        m.row = COORD_W'((ry * sh) / th);
        return m;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_dest_x   <= '0;
            s_dest_y   <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                pixel_t p;
                p = pixel_q.pop_front();
                s_valid  <= 1'b1;
                s_dest_x <= p.x;
                s_dest_y <= p.y;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left   <= ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 6) : 0;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left <= 300;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                mapping_q.push_back(map_pixel('{s_dest_x, s_dest_y}));
            if (m_valid && m_ready) begin
                if (mapping_q.size() == 0) begin
                    $display("%0t: result transaction with nothing expected", $time);
                    error_count++;
                end else begin
                    mapping_t e;
                    e = mapping_q.pop_front();
                    if (m_in_picture !== e.in_picture) begin
                        $display("%0t: in_picture expected %0d actual %0d",
                                 $time, e.in_picture, m_in_picture);
                        error_count++;
                    end
                    if (m_src_col !== e.col) begin
                        $display("%0t: src_col expected %0d actual %0d", $time, e.col, m_src_col);
                        error_count++;
                    end
                    if (m_src_row !== e.row) begin
                        $display("%0t: src_row expected %0d actual %0d", $time, e.row, m_src_row);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic wait_idle();
        while (pixel_q.size() > 0 || s_valid || mapping_q.size() > 0)
            @(negedge aclk);
        repeat (25) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            lnsa_pkg::CFG_SRC_WIDTH:  geo_sw = val;
            lnsa_pkg::CFG_SRC_HEIGHT: geo_sh = val;
            lnsa_pkg::CFG_DST_WIDTH:  geo_dw = val;
            lnsa_pkg::CFG_DST_HEIGHT: geo_dh = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_geometry(int sw, int sh, int dw, int dh);
        wait_idle();
        write_reg(lnsa_pkg::CFG_SRC_WIDTH, REG_W'(sw));
        write_reg(lnsa_pkg::CFG_SRC_HEIGHT, REG_W'(sh));
        write_reg(lnsa_pkg::CFG_DST_WIDTH, REG_W'(dw));
        write_reg(lnsa_pkg::CFG_DST_HEIGHT, REG_W'(dh));
    endtask

    task automatic add_pixel(int x, int y);
        pixel_q.push_back('{COORD_W'(x), COORD_W'(y)});
    endtask

    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return 0;
        if (r < 8) return MAX_DIM;
        if (r < 12) return $urandom_range(MAX_DIM + 1, 8191);
        if (r < 20) return $urandom_range(1, MAX_DIM);
        return $urandom_range(1, 48);
    endfunction

    function automatic int pick_coord(int dim);
        int lim;
        lim = (dim > MAX_DIM) ? MAX_DIM : dim;
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 4095);
        return $urandom_range(0, (lim + 2 > 4095) ? 4095 : lim + 2);
    endfunction

    initial begin
        int sw, sh, dw, dh;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_index  = '0;
        cfg_wr_data   = '0;
        geo_sw        = '0;
        geo_sh        = '0;
        geo_dw        = '0;
        geo_dh        = '0;
        error_count   = 0;
        gap_pct       = 30;
        stall_pct     = 20;
        long_hold_req = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Registers still at reset: everything is black fill.
        add_pixel(0, 0);
        add_pixel(4095, 4095);

        // Equal sizes at the largest frame: identity mapping.
        set_geometry(MAX_DIM, MAX_DIM, MAX_DIM, MAX_DIM);
        add_pixel(0, 0);
        add_pixel(4095, 4095);
        add_pixel(4095, 0);
        add_pixel(2730, 1365);

        // Oversized register values saturate; an unknown index must be ignored.
        set_geometry(8191, 100, 4096, 300);
        write_reg(CFG_UNUSED_IDX, 13'h1FFF);
        add_pixel(0, 50);
        add_pixel(4095, 150);
        add_pixel(2048, 299);

        // Pillarbox cases at the corners of the picture area, then a zero destination width.
        set_geometry(640, 480, 1920, 1080);
        add_pixel(239, 0);
        add_pixel(240, 0);
        add_pixel(1679, 1079);
        add_pixel(1680, 500);
        add_pixel(1919, 1080);
        set_geometry(1, 1, 4096, 1);
        add_pixel(0, 0);
        add_pixel(2047, 0);
        add_pixel(2048, 0);
        set_geometry(7, 3, 0, 5);
        add_pixel(0, 0);
        add_pixel(3, 2);

        for (int ph = 0; ph < 20; ph++) begin
            sw = pick_dim();
            sh = pick_dim();
            if ($urandom_range(0, 4) == 0) begin
                dw = sw;
                dh = sh;
            end else begin
                dw = pick_dim();
                dh = pick_dim();
            end
            set_geometry(sw, sh, dw, dh);
            gap_pct   = (ph % 4 == 0) ? 0 : $urandom_range(10, 60);
            stall_pct = (ph % 4 == 1) ? 0 : $urandom_range(10, 60);
            for (int i = 0; i < 25; i++)
                add_pixel(pick_coord(dw), pick_coord(dh));
            if (ph == 5) begin
                gap_pct = 0;
                long_hold_req = 1'b1;
            end
        end

        wait_idle();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/lnsa_pkg.sv
rtl/lnsa_setup.sv
rtl/lnsa_front.sv
rtl/lnsa_queue.sv
rtl/lnsa_back.sv
rtl/letterbox_nearest_scaler_address.sv
sim/tb_letterbox_nearest_scaler_address.sv
